### rtl/udpq_pkg.sv
// Shared types, codes and state encodings for the UDP port demultiplexer.
package udpq_pkg;

    localparam int LEN_W = 9;

    localparam logic [2:0] OP_BIND    = 3'd0;
    localparam logic [2:0] OP_UNBIND  = 3'd1;
    localparam logic [2:0] OP_DELIVER = 3'd2;
    localparam logic [2:0] OP_RECEIVE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NOPORT  = 3'd2;
    localparam logic [2:0] ST_BUSY    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_SMALL   = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] port;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [63:0] data;
        logic [3:0]  byte_count;
        logic        last;
        logic [15:0] capacity;
    } t_in;

    typedef struct packed {
        logic [2:0]       status;
        logic [63:0]      out_data;
        logic [3:0]       out_bytes;
        logic             out_last;
        logic [31:0]      out_src_ip;
        logic [15:0]      out_src_port;
        logic [LEN_W-1:0] out_length;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_EXEC, S_META, S_RDO, S_WR2, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE, D_OPEN, D_DROP_NOPORT, D_DROP_INVALID
    } t_dstate;

    typedef struct packed {
        logic set;
        logic clr;
        logic clr_all;
    } t_tbl_op;

    typedef struct packed {
        logic hit;
        logic free;
    } t_tbl_hit;

endpackage

### rtl/udpq_port_table.sv
// Bound-port table: entry registers with parallel port match and free-entry search.
module udpq_port_table #(
    parameter int PORT_SLOTS = 8,
    parameter int ENTRY_W    = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_port,
    input  udpq_pkg::t_tbl_op  i_op,
    input  logic [ENTRY_W-1:0] i_idx,
    output udpq_pkg::t_tbl_hit o_hit,
    output logic [ENTRY_W-1:0] o_hidx,
    output logic [ENTRY_W-1:0] o_fidx
);

    logic [15:0]           r_port [PORT_SLOTS];
    logic [PORT_SLOTS-1:0] r_bound;

    always_comb begin
        o_hit  = '0;
        o_hidx = '0;
        o_fidx = '0;
        for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
            if (r_bound[i] && r_port[i] == i_port) begin
                o_hit.hit = 1'b1;
                o_hidx    = ENTRY_W'(i);
            end
            if (!r_bound[i]) begin
                o_hit.free = 1'b1;
                o_fidx     = ENTRY_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
        end else if (i_op.clr_all) begin
            r_bound <= '0;
        end else if (i_op.set) begin
            r_bound[i_idx] <= 1'b1;
        end else if (i_op.clr) begin
            r_bound[i_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.set) begin
            r_port[i_idx] <= i_port;
        end
    end

endmodule

### rtl/udpq_store.sv
// Datagram storage: sender and length memories per slot, byte-writable payload memory.
module udpq_store #(
    parameter int SLOTS  = 32,
    parameter int SLOT_W = 5,
    parameter int PWORDS = 1024,
    parameter int PA_W   = 10,
    parameter int PW     = 9
) (
    input  logic              i_clk,
    input  logic              i_snd_we,
    input  logic [SLOT_W-1:0] i_snd_waddr,
    input  logic [47:0]       i_snd_wdata,
    input  logic              i_len_we,
    input  logic [SLOT_W-1:0] i_len_waddr,
    input  logic [PW-1:0]     i_len_wdata,
    input  logic              i_meta_re,
    input  logic [SLOT_W-1:0] i_meta_raddr,
    output logic [47:0]       o_snd_rdata,
    output logic [PW-1:0]     o_len_rdata,
    input  logic              i_pay_we,
    input  logic [PA_W-1:0]   i_pay_waddr,
    input  logic [63:0]       i_pay_wdata,
    input  logic [7:0]        i_pay_be,
    input  logic              i_pay_re,
    input  logic [PA_W-1:0]   i_pay_raddr,
    output logic [63:0]       o_pay_rdata
);

    logic [47:0]   r_snd_mem [SLOTS];
    logic [PW-1:0] r_len_mem [SLOTS];
    logic [63:0]   r_pay_mem [PWORDS];

    always_ff @(posedge i_clk) begin
        if (i_snd_we) begin
            r_snd_mem[i_snd_waddr] <= i_snd_wdata;
        end
        if (i_len_we) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        if (i_meta_re) begin
            o_snd_rdata <= r_snd_mem[i_meta_raddr];
            o_len_rdata <= r_len_mem[i_meta_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pay_we) begin
            for (int b = 0; b < 8; b++) begin
                if (i_pay_be[b]) begin
                    r_pay_mem[i_pay_waddr][b*8 +: 8] <= i_pay_wdata[b*8 +: 8];
                end
            end
        end
        if (i_pay_re) begin
            o_pay_rdata <= r_pay_mem[i_pay_raddr];
        end
    end

endmodule

### rtl/udp_port_demux_queues.sv
// Top level: UDP port demultiplexer with per-port receive rings.
//
//   channel  | handshake                       | payload
//   input    | i_in_valid, o_in_stall          | i_in  (udpq_pkg::t_in)
//   output   | o_out_valid, i_out_stall        | o_out (udpq_pkg::t_out)
//
// One item at a time: accept, table match and ring read, execute, result.
// Bind, unbind, clear and rejected operations go from execute to result, as does a
// deliver word; one whose bytes straddle two payload words first takes a second write.
// A good receive reads its metadata, then does one memory read per payload word.
// Synchronous active-low reset clears the port table and delivery state.
// A stalled result holds the output register; the next item is taken meanwhile.
module udp_port_demux_queues #(
    parameter int PORT_SLOTS  = 8,
    parameter int QUEUE_DEPTH = 4,
    parameter int PAYLOAD_MAX = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  udpq_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output udpq_pkg::t_out o_out
);

    localparam int ENTRY_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS   = PORT_SLOTS * QUEUE_DEPTH;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WPS     = (PAYLOAD_MAX + 7) / 8;
    localparam int WORD_W  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int PWORDS  = SLOTS * WPS;
    localparam int PA_W    = (PWORDS > 1) ? $clog2(PWORDS) : 1;
    localparam int PW      = $clog2(PAYLOAD_MAX + 1);

    udpq_pkg::t_state  r_state, n_state;
    udpq_pkg::t_dstate r_dstate, n_dstate;
    udpq_pkg::t_in     r_req;
    udpq_pkg::t_out    r_out, n_out;
    udpq_pkg::t_tbl_hit r_hit;
    logic               r_out_valid;
    logic               out_load;
    logic [ENTRY_W-1:0] r_hidx, r_fidx, r_open, n_open;
    logic [PW-1:0]      r_prog, n_prog, r_rem;
    logic [2:0]         r_status, n_status;
    logic [SLOT_W-1:0]  r_slot;
    logic [WORD_W-1:0]  r_k;
    logic [PA_W-1:0]    r_spill_addr;
    logic [63:0]        r_spill_data;
    logic [7:0]         r_spill_be;

    logic [HEAD_W-1:0]  r_ring_head_mem [PORT_SLOTS];
    logic [CNT_W-1:0]   r_ring_cnt_mem  [PORT_SLOTS];
    logic [HEAD_W-1:0]  r_ring_head;
    logic [CNT_W-1:0]   r_ring_cnt;
    logic               ring_re, ring_we;
    logic [ENTRY_W-1:0] ring_raddr, ring_waddr;
    logic [HEAD_W-1:0]  ring_whead;
    logic [CNT_W-1:0]   ring_wcnt;

    udpq_pkg::t_tbl_op  tbl_op;
    udpq_pkg::t_tbl_hit tbl_hit;
    logic [ENTRY_W-1:0] tbl_idx, tbl_hidx, tbl_fidx;

    logic              snd_we, len_we, meta_re, pay_we, pay_re;
    logic [SLOT_W-1:0] meta_raddr;
    logic [PA_W-1:0]   pay_waddr, pay_raddr;
    logic [63:0]       pay_wdata, pay_rdata;
    logic [7:0]        pay_be;
    logic [47:0]       snd_rdata;
    logic [PW-1:0]     len_rdata;

    logic [3:0]         bc;
    logic               first_w, full, over, recv_ok, too_small, out_free, rd_last;
    logic [HEAD_W-1:0]  head_inc, head1;
    logic [CNT_W-1:0]   cnt1;
    logic [CNT_W:0]     tsum;
    logic [HEAD_W-1:0]  tail;
    logic [ENTRY_W-1:0] entry_d;
    logic [SLOT_W-1:0]  dslot, rslot;
    logic [PW-1:0]      off;
    logic [PW:0]        sumprog;
    logic [7:0]         be8;
    logic [127:0]       wide_d;
    logic [15:0]        wide_be;
    logic [PA_W-1:0]    a0;
    logic [3:0]         nb;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign bc        = (r_req.byte_count > 4'd8) ? 4'd8 : r_req.byte_count;
    assign first_w   = (r_dstate == udpq_pkg::D_IDLE);
    assign full      = first_w && (r_ring_cnt == CNT_W'(QUEUE_DEPTH));
    assign head_inc  = (r_ring_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : r_ring_head + 1'b1;
    assign head1     = full ? head_inc : r_ring_head;
    assign cnt1      = full ? r_ring_cnt - 1'b1 : r_ring_cnt;
    assign tsum      = (CNT_W + 1)'(head1) + (CNT_W + 1)'(cnt1);
    assign tail      = HEAD_W'((tsum >= (CNT_W + 1)'(QUEUE_DEPTH))
                               ? tsum - (CNT_W + 1)'(QUEUE_DEPTH) : tsum);
    assign entry_d   = first_w ? r_hidx : r_open;
    assign dslot     = SLOT_W'(int'(entry_d) * QUEUE_DEPTH + int'(tail));
    assign rslot     = SLOT_W'(int'(r_hidx) * QUEUE_DEPTH + int'(r_ring_head));
    assign off       = first_w ? '0 : r_prog;
    assign sumprog   = (PW + 1)'(off) + (PW + 1)'(bc);
    assign over      = sumprog > (PW + 1)'(PAYLOAD_MAX);
    assign be8       = ~(8'hFF >> bc);
    assign wide_d    = {r_req.data, 64'd0} >> {off[2:0], 3'b000};
    assign wide_be   = {be8, 8'd0} >> off[2:0];
    assign a0        = PA_W'(int'(dslot) * WPS + int'(off >> 3));
    assign recv_ok   = r_hit.hit && (r_ring_cnt != '0);
    assign too_small = {1'b0, r_req.capacity} < 17'(len_rdata);
    assign rd_last   = r_rem <= PW'(8);
    assign nb        = rd_last ? 4'(r_rem) : 4'd8;

    udpq_port_table #(
        .PORT_SLOTS (PORT_SLOTS),
        .ENTRY_W    (ENTRY_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_port  (r_req.port),
        .i_op    (tbl_op),
        .i_idx   (tbl_idx),
        .o_hit   (tbl_hit),
        .o_hidx  (tbl_hidx),
        .o_fidx  (tbl_fidx)
    );

    udpq_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .PWORDS (PWORDS),
        .PA_W   (PA_W),
        .PW     (PW)
    ) u_store (
        .i_clk        (i_clk),
        .i_snd_we     (snd_we),
        .i_snd_waddr  (dslot),
        .i_snd_wdata  ({r_req.src_ip, r_req.src_port}),
        .i_len_we     (len_we),
        .i_len_waddr  (dslot),
        .i_len_wdata  (PW'(sumprog)),
        .i_meta_re    (meta_re),
        .i_meta_raddr (meta_raddr),
        .o_snd_rdata  (snd_rdata),
        .o_len_rdata  (len_rdata),
        .i_pay_we     (pay_we),
        .i_pay_waddr  (pay_waddr),
        .i_pay_wdata  (pay_wdata),
        .i_pay_be     (pay_be),
        .i_pay_re     (pay_re),
        .i_pay_raddr  (pay_raddr),
        .o_pay_rdata  (pay_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_head_mem[ring_waddr] <= ring_whead;
            r_ring_cnt_mem[ring_waddr]  <= ring_wcnt;
        end
        if (ring_re) begin
            r_ring_head <= r_ring_head_mem[ring_raddr];
            r_ring_cnt  <= r_ring_cnt_mem[ring_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            udpq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = udpq_pkg::S_LOOK;
            end
            udpq_pkg::S_LOOK: n_state = udpq_pkg::S_EXEC;
            udpq_pkg::S_EXEC: begin
                n_state = udpq_pkg::S_RESP;
                if (r_req.operation == udpq_pkg::OP_RECEIVE && recv_ok) begin
                    n_state = udpq_pkg::S_META;
                end else if (r_req.operation == udpq_pkg::OP_DELIVER
                             && (r_dstate == udpq_pkg::D_OPEN || (first_w && r_hit.hit))
                             && !over && wide_be[7:0] != '0) begin
                    n_state = udpq_pkg::S_WR2;
                end
            end
            udpq_pkg::S_META: n_state = too_small ? udpq_pkg::S_RESP : udpq_pkg::S_RDO;
            udpq_pkg::S_RDO: begin
                if (out_free && rd_last) n_state = udpq_pkg::S_IDLE;
            end
            udpq_pkg::S_WR2: n_state = udpq_pkg::S_RESP;
            udpq_pkg::S_RESP: begin
                if (out_free) n_state = udpq_pkg::S_IDLE;
            end
            default: n_state = udpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_dstate   = r_dstate;
        n_prog     = r_prog;
        n_open     = r_open;
        n_status   = r_status;
        n_out      = '0;
        out_load   = 1'b0;
        tbl_op     = '0;
        tbl_idx    = r_hidx;
        ring_re    = 1'b0;
        ring_raddr = tbl_hidx;
        ring_we    = 1'b0;
        ring_waddr = entry_d;
        ring_whead = head1;
        ring_wcnt  = cnt1;
        snd_we     = 1'b0;
        len_we     = 1'b0;
        meta_re    = 1'b0;
        meta_raddr = rslot;
        pay_we     = 1'b0;
        pay_waddr  = a0;
        pay_wdata  = wide_d[127:64];
        pay_be     = wide_be[15:8];
        pay_re     = 1'b0;
        pay_raddr  = PA_W'(int'(r_slot) * WPS);
        unique case (r_state)
            udpq_pkg::S_LOOK: begin
                ring_re = 1'b1;
                if (r_req.operation == udpq_pkg::OP_DELIVER && r_dstate == udpq_pkg::D_OPEN) begin
                    ring_raddr = r_open;
                end
            end
            udpq_pkg::S_EXEC: begin
                priority case (r_req.operation)
                    udpq_pkg::OP_BIND: begin
                        if (r_req.port == '0) begin
                            n_status = udpq_pkg::ST_INVALID;
                        end else if (r_hit.hit) begin
                            n_status = udpq_pkg::ST_OK;
                        end else if (r_hit.free) begin
                            n_status   = udpq_pkg::ST_OK;
                            tbl_op.set = 1'b1;
                            tbl_idx    = r_fidx;
                            ring_we    = 1'b1;
                            ring_waddr = r_fidx;
                            ring_whead = '0;
                            ring_wcnt  = '0;
                        end else begin
                            n_status = udpq_pkg::ST_BUSY;
                        end
                    end
                    udpq_pkg::OP_UNBIND: begin
                        if (r_hit.hit) begin
                            n_status   = udpq_pkg::ST_OK;
                            tbl_op.clr = 1'b1;
                            if (r_dstate == udpq_pkg::D_OPEN && r_open == r_hidx) begin
                                n_dstate = udpq_pkg::D_DROP_NOPORT;
                                n_prog   = '0;
                            end
                        end else begin
                            n_status = udpq_pkg::ST_NOPORT;
                        end
                    end
                    udpq_pkg::OP_DELIVER: begin
                        if (r_dstate == udpq_pkg::D_DROP_NOPORT
                            || r_dstate == udpq_pkg::D_DROP_INVALID) begin
                            n_status = (r_dstate == udpq_pkg::D_DROP_NOPORT)
                                       ? udpq_pkg::ST_NOPORT : udpq_pkg::ST_INVALID;
                            if (r_req.last) n_dstate = udpq_pkg::D_IDLE;
                        end else if (first_w && !r_hit.hit) begin
                            n_status = udpq_pkg::ST_NOPORT;
                            n_dstate = r_req.last ? udpq_pkg::D_IDLE : udpq_pkg::D_DROP_NOPORT;
                        end else begin
                            ring_we = 1'b1;
                            if (first_w) begin
                                n_open = r_hidx;
                                snd_we = 1'b1;
                            end
                            if (over) begin
                                n_status = udpq_pkg::ST_INVALID;
                                n_prog   = '0;
                                n_dstate = r_req.last ? udpq_pkg::D_IDLE
                                                      : udpq_pkg::D_DROP_INVALID;
                            end else begin
                                n_status = udpq_pkg::ST_OK;
                                pay_we   = wide_be[15:8] != '0;
                                if (r_req.last) begin
                                    len_we    = 1'b1;
                                    ring_wcnt = cnt1 + 1'b1;
                                    n_prog    = '0;
                                    n_dstate  = udpq_pkg::D_IDLE;
                                end else begin
                                    n_prog   = PW'(sumprog);
                                    n_dstate = udpq_pkg::D_OPEN;
                                end
                            end
                        end
                    end
                    udpq_pkg::OP_RECEIVE: begin
                        n_status = udpq_pkg::ST_EMPTY;
                        meta_re  = recv_ok;
                    end
                    udpq_pkg::OP_CLEAR: begin
                        n_status       = udpq_pkg::ST_OK;
                        tbl_op.clr_all = 1'b1;
                        n_dstate       = udpq_pkg::D_IDLE;
                        n_prog         = '0;
                        n_open         = '0;
                    end
                    default: n_status = udpq_pkg::ST_INVALID;
                endcase
            end
            udpq_pkg::S_META: begin
                n_status = udpq_pkg::ST_SMALL;
                if (!too_small) begin
                    ring_we    = 1'b1;
                    ring_waddr = r_hidx;
                    ring_whead = head_inc;
                    ring_wcnt  = r_ring_cnt - 1'b1;
                    pay_re     = 1'b1;
                end
            end
            udpq_pkg::S_RDO: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    n_out.status       = udpq_pkg::ST_OK;
                    n_out.out_data     = pay_rdata & ~({64{1'b1}} >> {nb, 3'b000});
                    n_out.out_bytes    = nb;
                    n_out.out_last     = rd_last;
                    n_out.out_src_ip   = snd_rdata[47:16];
                    n_out.out_src_port = snd_rdata[15:0];
                    n_out.out_length   = udpq_pkg::LEN_W'(len_rdata);
                    pay_re             = !rd_last;
                    pay_raddr          = PA_W'(int'(r_slot) * WPS + int'(r_k) + 1);
                end
            end
            udpq_pkg::S_WR2: begin
                pay_we    = 1'b1;
                pay_waddr = r_spill_addr;
                pay_wdata = r_spill_data;
                pay_be    = r_spill_be;
            end
            udpq_pkg::S_RESP: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    n_out.status   = r_status;
                    n_out.out_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= udpq_pkg::S_IDLE;
            r_dstate    <= udpq_pkg::D_IDLE;
            r_prog      <= '0;
            r_open      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstate <= n_dstate;
            r_prog   <= n_prog;
            r_open   <= n_open;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (out_load) r_out <= n_out;
        if (r_state == udpq_pkg::S_IDLE && i_in_valid) r_req <= i_in;
        if (r_state == udpq_pkg::S_LOOK) begin
            r_hit  <= tbl_hit;
            r_hidx <= tbl_hidx;
            r_fidx <= tbl_fidx;
        end
        if (r_state == udpq_pkg::S_EXEC) begin
            r_slot       <= rslot;
            r_spill_addr <= a0 + 1'b1;
            r_spill_data <= wide_d[63:0];
            r_spill_be   <= wide_be[7:0];
        end
        if (r_state == udpq_pkg::S_META) begin
            r_k   <= '0;
            r_rem <= len_rdata;
        end else if (r_state == udpq_pkg::S_RDO && out_free) begin
            r_k   <= r_k + 1'b1;
            r_rem <= r_rem - PW'(8);
        end
    end

    assign o_in_stall  = (r_state != udpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == udpq_pkg::S_LOOK)
        else $error("accepted transaction did not start lookup");
    a_prog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= PW'(PAYLOAD_MAX))
        else $error("delivery progress past payload limit");
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> ring_wcnt <= CNT_W'(QUEUE_DEPTH))
        else $error("ring count past depth");
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.out_bytes != '0 |-> o_out.status == udpq_pkg::ST_OK)
        else $error("payload word with error status");
    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == udpq_pkg::S_EXEC && r_req.operation == udpq_pkg::OP_CLEAR
        |=> r_dstate == udpq_pkg::D_IDLE)
        else $error("clear left a delivery open");
`endif

endmodule

### test/udp_port_demux_queues_test.sv
// Testbench for the UDP port demultiplexer: predicts each result and checks it field by field.
module udp_port_demux_queues_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;
    localparam int DEPTH = 4;
    localparam int PMAX  = 256;
    localparam int WPS   = PMAX / 8;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    udpq_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    udpq_pkg::t_out o_out;

    udp_port_demux_queues dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // predictor state
    logic [15:0]       tbl_port [SLOTS];
    logic              tbl_bound[SLOTS];
    int                rng_head [SLOTS];
    int                rng_count[SLOTS];
    logic [31:0]       sl_ip  [SLOTS*DEPTH];
    logic [15:0]       sl_port[SLOTS*DEPTH];
    int                sl_len [SLOTS*DEPTH];
    logic [63:0]       pay_mem[SLOTS*DEPTH*WPS];
    int                dlv_progress;
    udpq_pkg::t_dstate dlv_state;
    int                dlv_entry;

    udpq_pkg::t_out expected_results[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;

    initial i_clk = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int find_port(logic [15:0] p);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_bound[i] && tbl_port[i] == p) return i;
        return -1;
    endfunction

    function automatic void wipe_entry(int e);
        tbl_port[e] = '0;
        tbl_bound[e] = 1'b0;
        rng_head[e] = 0;
        rng_count[e] = 0;
    endfunction

    function automatic void wipe_table();
        for (int e = 0; e < SLOTS; e++) wipe_entry(e);
        dlv_progress = 0;
        dlv_state = udpq_pkg::D_IDLE;
        dlv_entry = 0;
    endfunction

    function automatic logic [2:0] deliver_word(udpq_pkg::t_in it);
        int e;
        int s;
        int bc;
        int off;
        logic [2:0] st;
        bc = (it.byte_count > 8) ? 8 : int'(it.byte_count);
        if (dlv_state == udpq_pkg::D_DROP_NOPORT || dlv_state == udpq_pkg::D_DROP_INVALID) begin
            st = (dlv_state == udpq_pkg::D_DROP_NOPORT) ? udpq_pkg::ST_NOPORT
                                                        : udpq_pkg::ST_INVALID;
            if (it.last) dlv_state = udpq_pkg::D_IDLE;
            return st;
        end
        if (dlv_state != udpq_pkg::D_OPEN) begin
            e = find_port(it.port);
            if (e < 0) begin
                dlv_state = it.last ? udpq_pkg::D_IDLE : udpq_pkg::D_DROP_NOPORT;
                return udpq_pkg::ST_NOPORT;
            end
            dlv_entry = e;
            if (rng_count[e] >= DEPTH) begin
                rng_head[e] = (rng_head[e] + 1) % DEPTH;
                rng_count[e]--;
            end
            s = e * DEPTH + (rng_head[e] + rng_count[e]) % DEPTH;
            sl_ip[s] = it.src_ip;
            sl_port[s] = it.src_port;
            dlv_progress = 0;
            dlv_state = udpq_pkg::D_OPEN;
        end
        e = dlv_entry;
        s = e * DEPTH + (rng_head[e] + rng_count[e]) % DEPTH;
        if (dlv_progress + bc > PMAX) begin
            dlv_progress = 0;
            dlv_state = it.last ? udpq_pkg::D_IDLE : udpq_pkg::D_DROP_INVALID;
            return udpq_pkg::ST_INVALID;
        end
        for (int i = 0; i < bc; i++) begin
            off = dlv_progress + i;
            pay_mem[s*WPS + off/8][(7 - off%8)*8 +: 8] = it.data[(7-i)*8 +: 8];
        end
        dlv_progress += bc;
        if (it.last) begin
            sl_len[s] = dlv_progress;
            rng_count[e]++;
            dlv_progress = 0;
            dlv_state = udpq_pkg::D_IDLE;
        end
        return udpq_pkg::ST_OK;
    endfunction

    function automatic void predict_results(udpq_pkg::t_in it);
        udpq_pkg::t_out r;
        int e;
        int s;
        int len;
        int nw;
        int nb;
        r = '0;
        r.out_last = 1'b1;
        case (it.operation)
            udpq_pkg::OP_BIND: begin
                if (it.port == 0) r.status = udpq_pkg::ST_INVALID;
                else if (find_port(it.port) >= 0) r.status = udpq_pkg::ST_OK;
                else begin
                    r.status = udpq_pkg::ST_BUSY;
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_bound[i]) begin
                            wipe_entry(i);
                            tbl_port[i] = it.port;
                            tbl_bound[i] = 1'b1;
                            r.status = udpq_pkg::ST_OK;
                            break;
                        end
                end
                expected_results.push_back(r);
            end
            udpq_pkg::OP_UNBIND: begin
                e = find_port(it.port);
                if (e < 0) r.status = udpq_pkg::ST_NOPORT;
                else begin
                    wipe_entry(e);
                    if (dlv_state == udpq_pkg::D_OPEN && dlv_entry == e) begin
                        dlv_state = udpq_pkg::D_DROP_NOPORT;
                        dlv_progress = 0;
                    end
                    r.status = udpq_pkg::ST_OK;
                end
                expected_results.push_back(r);
            end
            udpq_pkg::OP_DELIVER: begin
                r.status = deliver_word(it);
                expected_results.push_back(r);
            end
            udpq_pkg::OP_RECEIVE: begin
                e = find_port(it.port);
                if (e < 0 || rng_count[e] == 0) begin
                    r.status = udpq_pkg::ST_EMPTY;
                    expected_results.push_back(r);
                end else begin
                    s = e * DEPTH + rng_head[e];
                    len = sl_len[s];
                    if (it.capacity < len) begin
                        r.status = udpq_pkg::ST_SMALL;
                        expected_results.push_back(r);
                    end else begin
                        nw = (len + 7) / 8;
                        if (nw == 0) nw = 1;
                        for (int k = 0; k < nw; k++) begin
                            nb = (len == 0) ? 0 : ((len - 8*k > 8) ? 8 : len - 8*k);
                            r = '0;
                            r.status = udpq_pkg::ST_OK;
                            if (nb > 0)
                                r.out_data = pay_mem[s*WPS + k] & (~64'd0 << (64 - 8*nb));
                            r.out_bytes = 4'(nb);
                            r.out_last = (k + 1 == nw);
                            r.out_src_ip = sl_ip[s];
                            r.out_src_port = sl_port[s];
                            r.out_length = udpq_pkg::LEN_W'(len);
                            expected_results.push_back(r);
                        end
                        rng_head[e] = (rng_head[e] + 1) % DEPTH;
                        rng_count[e]--;
                    end
                end
            end
            udpq_pkg::OP_CLEAR: begin
                wipe_table();
                r.status = udpq_pkg::ST_OK;
                expected_results.push_back(r);
            end
            default: begin
                r.status = udpq_pkg::ST_INVALID;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // receiver side: stall at random, hold off on request
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        udpq_pkg::t_out x;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", o_out);
                errors++;
            end else begin
                x = expected_results.pop_front();
                if (o_out.status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, o_out.status); errors++;
                end
                if (o_out.out_data !== x.out_data) begin
                    $error("out_data exp %h got %h", x.out_data, o_out.out_data); errors++;
                end
                if (o_out.out_bytes !== x.out_bytes) begin
                    $error("out_bytes exp %0d got %0d", x.out_bytes, o_out.out_bytes); errors++;
                end
                if (o_out.out_last !== x.out_last) begin
                    $error("out_last exp %0d got %0d", x.out_last, o_out.out_last); errors++;
                end
                if (o_out.out_src_ip !== x.out_src_ip) begin
                    $error("out_src_ip exp %h got %h", x.out_src_ip, o_out.out_src_ip);
                    errors++;
                end
                if (o_out.out_src_port !== x.out_src_port) begin
                    $error("out_src_port exp %0d got %0d", x.out_src_port,
                           o_out.out_src_port);
                    errors++;
                end
                if (o_out.out_length !== x.out_length) begin
                    $error("out_length exp %0d got %0d", x.out_length, o_out.out_length);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(udpq_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_results(it);
    endtask

    function automatic udpq_pkg::t_in make_op(logic [2:0] op, logic [15:0] p);
        udpq_pkg::t_in it;
        it = '0;
        it.operation = op;
        it.port = p;
        it.capacity = 16'hFFFF;
        return it;
    endfunction

    task automatic send_datagram(logic [15:0] p, int len);
        udpq_pkg::t_in it;
        int left;
        left = len;
        it = make_op(udpq_pkg::OP_DELIVER, p);
        it.src_ip = $urandom;
        it.src_port = 16'($urandom);
        do begin
            it.data = {$urandom, $urandom};
            it.byte_count = 4'((left > 8) ? 8 : left);
            if (left <= 8 && $urandom_range(9) == 0) it.byte_count = 4'($urandom_range(15, 9));
            it.last = (left <= 8);
            left -= 8;
            send_item(it);
            it.port = 16'($urandom);
            it.src_ip = $urandom;
            it.src_port = 16'($urandom);
        end while (left > 0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_table_ops();
        udpq_pkg::t_in it;
        send_item(make_op(udpq_pkg::OP_BIND, 16'd0));
        for (int i = 1; i <= SLOTS; i++)
            send_item(make_op(udpq_pkg::OP_BIND, 16'(16'hFFF0 + i)));
        send_item(make_op(udpq_pkg::OP_BIND, 16'hFFF1));
        send_item(make_op(udpq_pkg::OP_BIND, 16'd7));
        send_item(make_op(udpq_pkg::OP_UNBIND, 16'd7));
        send_item(make_op(udpq_pkg::OP_UNBIND, 16'hFFF8));
        send_item(make_op(udpq_pkg::OP_RECEIVE, 16'hFFF1));
        it = make_op(3'd5, 16'd1);
        send_item(it);
        it.operation = 3'd7;
        send_item(it);
    endtask

    task automatic test_deliver_receive();
        udpq_pkg::t_in it;
        send_datagram(16'hFFF1, 0);
        send_datagram(16'hFFF1, 13);
        send_datagram(16'hFFF1, PMAX);
        it = make_op(udpq_pkg::OP_RECEIVE, 16'hFFF1);
        send_item(it);
        it.capacity = 0;
        send_item(it);
        it.capacity = 16'hFFFF;
        send_item(it);
        send_item(it);
        // oversize and no-such-port discards
        send_datagram(16'hFFF2, PMAX + 8);
        send_datagram(16'h1234, 20);
        // unbind mid-delivery
        it = make_op(udpq_pkg::OP_DELIVER, 16'hFFF3);
        it.byte_count = 8;
        it.data = '1;
        send_item(it);
        send_item(make_op(udpq_pkg::OP_UNBIND, 16'hFFF3));
        it.last = 1'b1;
        send_item(it);
        send_item(make_op(udpq_pkg::OP_CLEAR, 16'd0));
    endtask

    task automatic test_random(int count);
        logic [15:0] ports[4];
        int n;
        int k;
        int len;
        n = 0;
        for (int i = 0; i < 4; i++)
            ports[i] = (i == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
        while (n < count) begin
            k = $urandom_range(99);
            if (k < 15) begin
                send_item(make_op(udpq_pkg::OP_BIND, $urandom_range(9) == 0 ? 16'd0 :
                                            ports[$urandom_range(3)]));
                n++;
            end else if (k < 50) begin
                len = $urandom_range(3) == 0 ? $urandom_range(PMAX + 9) : $urandom_range(24);
                send_datagram(ports[$urandom_range(3)], len);
                n += (len == 0) ? 1 : (len + 7) / 8;
            end else if (k < 85) begin
                udpq_pkg::t_in it;
                it = make_op(udpq_pkg::OP_RECEIVE, ports[$urandom_range(3)]);
                it.capacity = ($urandom_range(4) == 0) ? 16'($urandom_range(20))
                                                       : 16'($urandom);
                send_item(it);
                n++;
            end else if (k < 93) begin
                send_item(make_op(udpq_pkg::OP_UNBIND, ports[$urandom_range(3)]));
                n++;
            end else begin
                udpq_pkg::t_in it;
                logic [159:0]  raw;
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                it = raw[$bits(udpq_pkg::t_in)-1:0];
                if (it.operation == udpq_pkg::OP_DELIVER) it.last = 1'b1;
                if ($urandom_range(2) != 0) it.operation = udpq_pkg::OP_CLEAR;
                send_item(it);
                n++;
            end
        end
    endtask

    task automatic test_backpressure();
        drain();
        send_item(make_op(udpq_pkg::OP_BIND, 16'd99));
        hold_off = 200;
        for (int i = 0; i < 6; i++) send_datagram(16'd99, 16);
        for (int i = 0; i < 5; i++) send_item(make_op(udpq_pkg::OP_RECEIVE, 16'd99));
        drain();
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wipe_table();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_out_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_ops();
        test_deliver_receive();
        test_random(27);
        send_idle_pct = 67;
        test_random(27);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(27);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(27);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
